FILE: src/vvd_pkg.sv
// ----------------------------------------------------------------------------
// vvd_pkg: shared types and constants for the ellipsoid value dilation block
// Holds the sequencer states, register indexes, multiplier widths and the
// small helper functions that build the ellipsoid mask.
// ----------------------------------------------------------------------------
package vvd_pkg;

    localparam int K_MAX_X_DEF      = 32;
    localparam int K_MAX_Y_DEF      = 32;
    localparam int K_MAX_Z_DEF      = 32;
    localparam int K_VALUE_BITS_DEF = 16;

    // Largest kernel size along one axis.
    localparam logic [2:0] K_MAX_KERNEL = 3'd7;

    // Shared multiplier: a coefficient of up to 7^4 times a square of up to 7^2.
    localparam int K_MUL_A_BITS = 12;
    localparam int K_MUL_B_BITS = 6;
    localparam int K_PROD_BITS  = K_MUL_A_BITS + K_MUL_B_BITS;

    // Setup runs one multiplier step per cycle, followed by a final store of the last product.
    localparam logic [4:0] K_SETUP_LAST = 5'd25;

    typedef logic [2:0] t_cfg_index;
    localparam t_cfg_index CFG_ERODE    = 3'd0;
    localparam t_cfg_index CFG_DILATE   = 3'd1;
    localparam t_cfg_index CFG_KERNEL_X = 3'd2;
    localparam t_cfg_index CFG_KERNEL_Y = 3'd3;
    localparam t_cfg_index CFG_KERNEL_Z = 3'd4;
    localparam t_cfg_index CFG_SIZE_X   = 3'd5;
    localparam t_cfg_index CFG_SIZE_Y   = 3'd6;
    localparam t_cfg_index CFG_SIZE_Z   = 3'd7;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_WRITE,
        ST_READ_C,
        ST_WAIT_C,
        ST_SETUP,
        ST_SCAN,
        ST_DRAIN,
        ST_OUT
    } t_state;

    typedef enum logic [2:0] {
        STEP_COEF_Z,
        STEP_COEF_Y,
        STEP_COEF_X,
        STEP_LIM,
        STEP_TX,
        STEP_TY,
        STEP_TZ,
        STEP_NONE
    } t_step_kind;

    typedef struct packed {
        t_step_kind kind;
        logic [2:0] idx;
    } t_step;

    // Maps a setup step number to the product it computes.
    function automatic t_step step_decode(input logic [4:0] sc);
        t_step st;
        st.kind = STEP_NONE;
        st.idx  = 3'd0;
        if (sc == 5'd0) begin
            st.kind = STEP_COEF_Z;
        end else if (sc == 5'd1) begin
            st.kind = STEP_COEF_Y;
        end else if (sc == 5'd2) begin
            st.kind = STEP_COEF_X;
        end else if (sc == 5'd3) begin
            st.kind = STEP_LIM;
        end else if (sc < 5'd11) begin
            st.kind = STEP_TX;
            st.idx  = 3'(sc - 5'd4);
        end else if (sc < 5'd18) begin
            st.kind = STEP_TY;
            st.idx  = 3'(sc - 5'd11);
        end else if (sc < 5'd25) begin
            st.kind = STEP_TZ;
            st.idx  = 3'(sc - 5'd18);
        end
        return st;
    endfunction

    function automatic logic [5:0] square3(input logic [2:0] v);
        logic [5:0] sq;
        case (v)
            3'd0:    sq = 6'd0;
            3'd1:    sq = 6'd1;
            3'd2:    sq = 6'd4;
            3'd3:    sq = 6'd9;
            3'd4:    sq = 6'd16;
            3'd5:    sq = 6'd25;
            3'd6:    sq = 6'd36;
            default: sq = 6'd49;
        endcase
        return sq;
    endfunction

    // A size of zero acts as one; sizes above the maximum saturate.
    function automatic logic [2:0] kernel_eff(input logic [2:0] k);
        logic [2:0] e;
        if (k == 3'd0) begin
            e = 3'd1;
        end else if (k > K_MAX_KERNEL) begin
            e = K_MAX_KERNEL;
        end else begin
            e = k;
        end
        return e;
    endfunction

    // |2t - s + 1|, only meaningful for t below s, where it is at most 6.
    function automatic logic [2:0] axis_dist(input logic [2:0] t, input logic [2:0] s);
        logic signed [4:0] d;
        logic signed [4:0] a;
        d = $signed({1'b0, t, 1'b1}) - $signed({2'b00, s});
        a = (d < 0) ? -d : d;
        return a[2:0];
    endfunction

endpackage

FILE: src/vvd_mul_unit.sv
// ----------------------------------------------------------------------------
// vvd_mul_unit: shared registered multiplier
// Computes the ellipsoid coefficients, the limit and the per-axis mask terms,
// one product per cycle, with the result registered.
// ----------------------------------------------------------------------------
module vvd_mul_unit (
    input  logic                             i_clk,
    input  logic [vvd_pkg::K_MUL_A_BITS-1:0] i_a,
    input  logic [vvd_pkg::K_MUL_B_BITS-1:0] i_b,
    output logic [vvd_pkg::K_PROD_BITS-1:0]  o_prod
);
    import vvd_pkg::*;

    logic [K_PROD_BITS-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= K_PROD_BITS'(i_a) * K_PROD_BITS'(i_b);
    end

    assign o_prod = r_prod;

endmodule

FILE: src/vvd_volume_mem.sv
// ----------------------------------------------------------------------------
// vvd_volume_mem: voxel storage
// Single-port memory: one write or one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module vvd_volume_mem #(
    parameter int DEPTH = 32768,
    parameter int AW    = 15,
    parameter int WIDTH = 16
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_addr] <= i_wdata;
        end
        r_rdata <= mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/volume_value_dilation_ellipsoid.sv
// ----------------------------------------------------------------------------
// volume_value_dilation_ellipsoid: 3D value dilation with an ellipsoid kernel
// Holds a voxel volume; write beats load voxels, query beats return the
// filtered value of one voxel.
// ----------------------------------------------------------------------------
// Usage:
// Input beats (i_in_valid / o_in_ready) carry op, position and voxel value.
// A write beat stores one voxel and produces no output. A query beat produces
// exactly one output beat (o_out_valid / i_out_ready) with the filtered value.
// One beat is processed at a time; o_in_ready is high only while idle.
// A write passes through ST_REDUCE and ST_WRITE before ready returns. A query
// whose center voxel is not the erode value returns that value through
// ST_READ_C, ST_WAIT_C and ST_OUT. Otherwise a setup builds the mask terms on
// the shared multiplier, then the neighborhood is scanned at one memory read
// per cycle over kx*ky*kz positions plus a drain of the read pipeline, ending
// early on the first match. The single-port voxel memory sets the scan rate.
// Positions at or above the volume maximum are reduced by one subtraction per
// cycle before the access. Configuration writes are taken at any cycle and
// belong in idle periods. Reset restores the register defaults and the idle
// state; the voxel memory is not cleared. A stalled receiver does not block
// the next input beat; only a second result waits until the first is taken.
// ----------------------------------------------------------------------------
module volume_value_dilation_ellipsoid #(
    parameter int MAX_X      = vvd_pkg::K_MAX_X_DEF,
    parameter int MAX_Y      = vvd_pkg::K_MAX_Y_DEF,
    parameter int MAX_Z      = vvd_pkg::K_MAX_Z_DEF,
    parameter int VALUE_BITS = vvd_pkg::K_VALUE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_op,
    input  logic [4:0]            i_pos_x,
    input  logic [4:0]            i_pos_y,
    input  logic [4:0]            i_pos_z,
    input  logic [15:0]           i_voxel_in,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [15:0]           o_voxel_out,
    input  logic                  i_cfg_we,
    input  vvd_pkg::t_cfg_index   i_cfg_index,
    input  logic [15:0]           i_cfg_data
);
    import vvd_pkg::*;

    localparam int DEPTH    = MAX_X * MAX_Y * MAX_Z;
    localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RX       = (MAX_X < 32) ? MAX_X : 32;
    localparam int RY       = (MAX_Y < 32) ? MAX_Y : 32;
    localparam int RZ       = (MAX_Z < 32) ? MAX_Z : 32;
    localparam int STRIDE_Y = MAX_X;
    localparam int STRIDE_Z = MAX_X * MAX_Y;

    // Configuration registers.
    logic [15:0] r_erode, r_dilate;
    logic [2:0]  r_kx, r_ky, r_kz;
    logic [5:0]  r_size_x, r_size_y, r_size_z;

    // Sequencer and item registers.
    t_state                r_state, n_state;
    logic                  r_op;
    logic [4:0]            r_px, r_py, r_pz;
    logic [VALUE_BITS-1:0] r_wdata;
    logic [VALUE_BITS-1:0] r_center;

    // Mask construction.
    logic [4:0]              r_sc;
    logic [K_MUL_A_BITS-1:0] r_coef_x, r_coef_y, r_coef_z;
    logic [K_PROD_BITS-1:0]  r_lim;
    logic [K_PROD_BITS-1:0]  r_tx [7];
    logic [K_PROD_BITS-1:0]  r_ty [7];
    logic [K_PROD_BITS-1:0]  r_tz [7];

    // Neighborhood scan.
    logic [2:0] r_i, r_j, r_k;
    logic [5:0] r_nx, r_ny, r_nz;
    logic       r_probe, r_rd_pend;

    // Output register.
    logic        r_out_valid;
    logic [15:0] r_out_data;

    // Combinational signals.
    logic [2:0]              kx, ky, kz;
    logic [5:0]              sx2, sy2, sz2;
    logic [5:0]              ex, ey, ez;
    logic                    need_x, need_y, need_z;
    logic signed [7:0]       nx_s, ny_s, nz_s;
    logic                    in_x, in_y, in_z, in_mask, cand;
    logic [K_PROD_BITS:0]    mask_sum;
    logic                    last_i, last_j, last_k;
    logic [AW-1:0]           center_addr, nbr_addr;
    logic [VALUE_BITS-1:0]   erode_v, dilate_v;
    logic                    hit;
    t_step                   cur_step, prev_step;
    logic [K_MUL_A_BITS-1:0] mul_a;
    logic [K_MUL_B_BITS-1:0] mul_b;
    logic [K_PROD_BITS-1:0]  mul_prod;
    logic                    mem_we;
    logic [AW-1:0]           mem_addr;
    logic [VALUE_BITS-1:0]   mem_rdata;
    logic                    out_load;
    logic                    in_ready;

    assign kx  = kernel_eff(r_kx);
    assign ky  = kernel_eff(r_ky);
    assign kz  = kernel_eff(r_kz);
    assign sx2 = square3(kx);
    assign sy2 = square3(ky);
    assign sz2 = square3(kz);

    // Effective extents saturate at the volume maximum.
    assign ex = (32'(r_size_x) > MAX_X) ? 6'(MAX_X) : r_size_x;
    assign ey = (32'(r_size_y) > MAX_Y) ? 6'(MAX_Y) : r_size_y;
    assign ez = (32'(r_size_z) > MAX_Z) ? 6'(MAX_Z) : r_size_z;

    assign need_x = ({1'b0, r_px} >= 6'(RX));
    assign need_y = ({1'b0, r_py} >= 6'(RY));
    assign need_z = ({1'b0, r_pz} >= 6'(RZ));

    assign nx_s = $signed({3'b000, r_px}) + $signed({5'b00000, r_i})
                - $signed({5'b00000, (kx >> 1)});
    assign ny_s = $signed({3'b000, r_py}) + $signed({5'b00000, r_j})
                - $signed({5'b00000, (ky >> 1)});
    assign nz_s = $signed({3'b000, r_pz}) + $signed({5'b00000, r_k})
                - $signed({5'b00000, (kz >> 1)});

    assign in_x = (nx_s >= 0) && (nx_s < $signed({2'b00, ex}));
    assign in_y = (ny_s >= 0) && (ny_s < $signed({2'b00, ey}));
    assign in_z = (nz_s >= 0) && (nz_s < $signed({2'b00, ez}));

    assign mask_sum = (K_PROD_BITS+1)'(r_tx[r_i]) + (K_PROD_BITS+1)'(r_ty[r_j])
                    + (K_PROD_BITS+1)'(r_tz[r_k]);
    assign in_mask  = (mask_sum <= (K_PROD_BITS+1)'(r_lim));
    assign cand     = in_x && in_y && in_z && in_mask;

    assign last_i = (r_i == kx - 3'd1);
    assign last_j = (r_j == ky - 3'd1);
    assign last_k = (r_k == kz - 3'd1);

    assign center_addr = AW'(r_px) + AW'(STRIDE_Y) * AW'(r_py) + AW'(STRIDE_Z) * AW'(r_pz);
    assign nbr_addr    = AW'(r_nx) + AW'(STRIDE_Y) * AW'(r_ny) + AW'(STRIDE_Z) * AW'(r_nz);

    assign erode_v  = VALUE_BITS'(r_erode);
    assign dilate_v = VALUE_BITS'(r_dilate);
    assign hit      = r_rd_pend && (mem_rdata == dilate_v);

    // The multiplier result of a step lands in the cycle after it is issued.
    assign cur_step  = step_decode(r_sc);
    assign prev_step = step_decode(r_sc - 5'd1);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cur_step.kind)
            STEP_COEF_Z: begin
                mul_a = K_MUL_A_BITS'(sx2);
                mul_b = sy2;
            end
            STEP_COEF_Y: begin
                mul_a = K_MUL_A_BITS'(sx2);
                mul_b = sz2;
            end
            STEP_COEF_X: begin
                mul_a = K_MUL_A_BITS'(sy2);
                mul_b = sz2;
            end
            STEP_LIM: begin
                mul_a = r_coef_z;
                mul_b = sz2;
            end
            STEP_TX: begin
                mul_a = r_coef_x;
                mul_b = square3(axis_dist(cur_step.idx, kx));
            end
            STEP_TY: begin
                mul_a = r_coef_y;
                mul_b = square3(axis_dist(cur_step.idx, ky));
            end
            STEP_TZ: begin
                mul_a = r_coef_z;
                mul_b = square3(axis_dist(cur_step.idx, kz));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    vvd_mul_unit u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (mul_prod)
    );

    vvd_volume_mem #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .WIDTH (VALUE_BITS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (r_wdata),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        in_ready = 1'b0;
        mem_we   = 1'b0;
        mem_addr = center_addr;
        out_load = 1'b0;
        case (r_state)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = ST_REDUCE;
                end
            end
            ST_REDUCE: begin
                if (!need_x && !need_y && !need_z) begin
                    n_state = (r_op == OP_WRITE) ? ST_WRITE : ST_READ_C;
                end
            end
            ST_WRITE: begin
                mem_we  = 1'b1;
                n_state = ST_IDLE;
            end
            ST_READ_C: begin
                n_state = ST_WAIT_C;
            end
            ST_WAIT_C: begin
                n_state = (mem_rdata == erode_v) ? ST_SETUP : ST_OUT;
            end
            ST_SETUP: begin
                if (r_sc == K_SETUP_LAST) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                mem_addr = nbr_addr;
                if (hit) begin
                    n_state = ST_OUT;
                end else if (last_i && last_j && last_k) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                mem_addr = nbr_addr;
                if (hit || (!r_probe && !r_rd_pend)) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                out_load = !r_out_valid || i_out_ready;
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_erode     <= 16'd255;
            r_dilate    <= 16'd0;
            r_kx        <= 3'd1;
            r_ky        <= 3'd1;
            r_kz        <= 3'd1;
            r_size_x    <= 6'd32;
            r_size_y    <= 6'd32;
            r_size_z    <= 6'd32;
            r_sc        <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_k         <= '0;
            r_probe     <= 1'b0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_ERODE:    r_erode  <= i_cfg_data;
                    CFG_DILATE:   r_dilate <= i_cfg_data;
                    CFG_KERNEL_X: r_kx     <= i_cfg_data[2:0];
                    CFG_KERNEL_Y: r_ky     <= i_cfg_data[2:0];
                    CFG_KERNEL_Z: r_kz     <= i_cfg_data[2:0];
                    CFG_SIZE_X:   r_size_x <= i_cfg_data[5:0];
                    CFG_SIZE_Y:   r_size_y <= i_cfg_data[5:0];
                    CFG_SIZE_Z:   r_size_z <= i_cfg_data[5:0];
                    default:      r_erode  <= r_erode;
                endcase
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_WAIT_C: begin
                    r_sc      <= '0;
                    r_i       <= '0;
                    r_j       <= '0;
                    r_k       <= '0;
                    r_probe   <= 1'b0;
                    r_rd_pend <= 1'b0;
                end
                ST_SETUP: begin
                    r_sc <= r_sc + 5'd1;
                end
                ST_SCAN: begin
                    // Stage one checks bounds and mask, stage two reads,
                    // stage three compares the read data.
                    r_probe   <= cand && !hit;
                    r_rd_pend <= r_probe && !hit;
                    if (last_i) begin
                        r_i <= '0;
                        if (last_j) begin
                            r_j <= '0;
                            r_k <= r_k + 3'd1;
                        end else begin
                            r_j <= r_j + 3'd1;
                        end
                    end else begin
                        r_i <= r_i + 3'd1;
                    end
                end
                ST_DRAIN: begin
                    r_probe   <= 1'b0;
                    r_rd_pend <= r_probe && !hit;
                end
                default: begin
                    r_probe   <= 1'b0;
                    r_rd_pend <= 1'b0;
                end
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid && in_ready) begin
                    r_op    <= i_op;
                    r_px    <= i_pos_x;
                    r_py    <= i_pos_y;
                    r_pz    <= i_pos_z;
                    r_wdata <= VALUE_BITS'(i_voxel_in);
                end
            end
            ST_REDUCE: begin
                if (need_x) begin
                    r_px <= r_px - 5'(RX);
                end
                if (need_y) begin
                    r_py <= r_py - 5'(RY);
                end
                if (need_z) begin
                    r_pz <= r_pz - 5'(RZ);
                end
            end
            ST_WAIT_C: begin
                r_center <= mem_rdata;
            end
            ST_SETUP: begin
                if (r_sc != 5'd0) begin
                    case (prev_step.kind)
                        STEP_COEF_Z: r_coef_z <= K_MUL_A_BITS'(mul_prod);
                        STEP_COEF_Y: r_coef_y <= K_MUL_A_BITS'(mul_prod);
                        STEP_COEF_X: r_coef_x <= K_MUL_A_BITS'(mul_prod);
                        STEP_LIM:    r_lim    <= mul_prod;
                        STEP_TX:     r_tx[prev_step.idx] <= mul_prod;
                        STEP_TY:     r_ty[prev_step.idx] <= mul_prod;
                        STEP_TZ:     r_tz[prev_step.idx] <= mul_prod;
                        default:     r_lim    <= r_lim;
                    endcase
                end
            end
            ST_SCAN: begin
                r_nx <= nx_s[5:0];
                r_ny <= ny_s[5:0];
                r_nz <= nz_s[5:0];
                if (hit) begin
                    r_center <= dilate_v;
                end
            end
            ST_DRAIN: begin
                if (hit) begin
                    r_center <= dilate_v;
                end
            end
            default: begin
                r_center <= r_center;
            end
        endcase

        if (out_load) begin
            r_out_data <= 16'(r_center);
        end
    end

    assign o_in_ready  = in_ready;
    assign o_out_valid = r_out_valid;
    assign o_voxel_out = r_out_data;

    a_accept_reduce: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == ST_REDUCE))
        else $error("accepted beat did not start position reduction");

    a_coords_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WRITE || r_state == ST_READ_C) |->
        (({1'b0, r_px} < 6'(RX)) && ({1'b0, r_py} < 6'(RY)) && ({1'b0, r_pz} < 6'(RZ))))
        else $error("memory access with an unreduced position");

    a_setup_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SETUP) |-> (r_sc <= K_SETUP_LAST))
        else $error("setup step counter ran past the last step");

    a_probe_scope: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_probe || r_rd_pend) |-> (r_state == ST_SCAN || r_state == ST_DRAIN))
        else $error("neighbor read pending outside the scan");

    a_probe_in_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_probe |-> ((r_nx < ex) && (r_ny < ey) && (r_nz < ez)))
        else $error("neighbor read outside the volume extent");

endmodule
